/* sv/obb_pkg.sv */
`timescale 1ns / 1ps
package obb_pkg;

    localparam int COORD_W  = 32;
    localparam int ROT_W    = 16;
    localparam int AXIS_W   = 2 * ROT_W + 1;
    localparam int PROD_W   = AXIS_W + COORD_W;
    localparam int PROJ_W   = PROD_W + 2;
    localparam int LIMIT_W  = 16;
    localparam int N_CORNER = 16;
    localparam int N_ROT    = 6;
    localparam logic [3:0] LAST_AXIS  = 4'd14;
    localparam logic [3:0] FIRST_CROSS = 4'd6;

    typedef logic signed [COORD_W-1:0] corner_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PROJ_W-1:0]  proj_t;

    typedef struct packed {
        logic [2:0] a;
        logic [2:0] b;
    } pair_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       axis_load;
        logic [3:0] axis_idx;
        logic       issue;
        logic [3:0] corner_idx;
        logic       judge;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic out_valid;
    } status_t;

    // Rotation columns feeding each test axis: faces first, then cross pairs
    function automatic pair_t axis_pair(input logic [3:0] k);
        pair_t p;
        p = '{a: 3'd0, b: 3'd0};
        unique case (k)
            4'd0:  p = '{a: 3'd0, b: 3'd0};
            4'd1:  p = '{a: 3'd1, b: 3'd0};
            4'd2:  p = '{a: 3'd2, b: 3'd0};
            4'd3:  p = '{a: 3'd3, b: 3'd0};
            4'd4:  p = '{a: 3'd4, b: 3'd0};
            4'd5:  p = '{a: 3'd5, b: 3'd0};
            4'd6:  p = '{a: 3'd0, b: 3'd3};
            4'd7:  p = '{a: 3'd0, b: 3'd4};
            4'd8:  p = '{a: 3'd0, b: 3'd5};
            4'd9:  p = '{a: 3'd1, b: 3'd3};
            4'd10: p = '{a: 3'd1, b: 3'd4};
            4'd11: p = '{a: 3'd1, b: 3'd5};
            4'd12: p = '{a: 3'd2, b: 3'd3};
            4'd13: p = '{a: 3'd2, b: 3'd4};
            4'd14: p = '{a: 3'd2, b: 3'd5};
            default: p = '{a: 3'd0, b: 3'd0};
        endcase
        return p;
    endfunction

endpackage

/* sv/obb_ctrl.sv */
`timescale 1ns / 1ps
module obb_ctrl
    import obb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  logic    m_tready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {IDLE, AXIS, CHECK, DOT, DRAIN, JUDGE, DONE} state_t;

    state_t     state_reg, state_next;
    logic [3:0] ax_reg, ax_next;
    logic [3:0] ci_reg, ci_next;

    assign s_tready = (state_reg == IDLE);

    // Sequence axes, corners and the final judgement
    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ci_next        = ci_reg;
        cmd            = '0;
        cmd.axis_idx   = ax_reg;
        cmd.corner_idx = ci_reg;
        unique case (state_reg)
            IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    cmd.start  = 1'b1;
                    ax_next    = '0;
                    state_next = AXIS;
                end
            end
            AXIS:
            begin
                cmd.axis_load = 1'b1;
                state_next    = CHECK;
            end
            CHECK:
            begin
                ci_next = '0;
                if (!st.skip)
                    state_next = DOT;
                else if (ax_reg == LAST_AXIS)
                    state_next = DONE;
                else
                begin
                    ax_next    = ax_reg + 4'd1;
                    state_next = AXIS;
                end
            end
            DOT:
            begin
                cmd.issue = 1'b1;
                ci_next   = ci_reg + 4'd1;
                if (ci_reg == 4'(N_CORNER - 1))
                    state_next = DRAIN;
            end
            DRAIN:
                state_next = JUDGE;
            JUDGE:
            begin
                cmd.judge = 1'b1;
                if (ax_reg == LAST_AXIS)
                    state_next = DONE;
                else
                begin
                    ax_next    = ax_reg + 4'd1;
                    state_next = AXIS;
                end
            end
            DONE:
            begin
                if (!st.out_valid || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
                state_next = IDLE;
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ax_reg    <= '0;
            ci_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            ci_reg    <= ci_next;
        end
    end

endmodule

/* sv/obb_datapath.sv */
`timescale 1ns / 1ps
module obb_datapath
    import obb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic [4:0]           s_tuser,
    input  logic [95:0]          s_tdata,
    input  logic                 cfg_we,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata
);

    corner_t corner_reg [N_CORNER][3];
    rot_t    rot_reg    [N_ROT][3];
    logic [LIMIT_W-1:0] limit_reg;

    axis_t axis_reg [3];
    logic  cross_reg;

    prod_t prod_reg [3];
    logic  p_valid_reg;
    logic [3:0] p_idx_reg;

    proj_t proj_reg [N_CORNER];
    proj_t lo_reg [2];
    proj_t hi_reg [2];

    logic [15:0] mask_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    pair_t pair;
    rot_t  ra [3];
    rot_t  rb [3];
    logic signed [2*ROT_W-1:0] m12, m21, m20, m02, m01, m10;
    axis_t cross_vec [3];
    logic  big;
    logic [AXIS_W-1:0] mag [3];
    proj_t sum;
    logic  box;
    logic [15:0] keep;

    // Register the cross limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    // Store corners and rotation columns
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (!s_tuser[0])
            begin
                corner_reg[{s_tuser[1], s_tuser[4:2]}][0] <= s_tdata[31:0];
                corner_reg[{s_tuser[1], s_tuser[4:2]}][1] <= s_tdata[63:32];
                corner_reg[{s_tuser[1], s_tuser[4:2]}][2] <= s_tdata[95:64];
            end
            else if (s_tuser[4:2] < 3'd3)
            begin
                rot_reg[3'(s_tuser[1] ? 3'd3 + s_tuser[4:2] : s_tuser[4:2])][0]
                    <= s_tdata[ROT_W-1:0];
                rot_reg[3'(s_tuser[1] ? 3'd3 + s_tuser[4:2] : s_tuser[4:2])][1]
                    <= s_tdata[32+ROT_W-1:32];
                rot_reg[3'(s_tuser[1] ? 3'd3 + s_tuser[4:2] : s_tuser[4:2])][2]
                    <= s_tdata[64+ROT_W-1:64];
            end
        end
    end

    // Form the current axis
    always_comb
    begin
        pair = axis_pair(cmd.axis_idx);
        for (int k = 0; k < 3; k++)
        begin
            ra[k] = rot_reg[pair.a][k];
            rb[k] = rot_reg[pair.b][k];
        end
        m12 = ra[1] * rb[2];
        m21 = ra[2] * rb[1];
        m20 = ra[2] * rb[0];
        m02 = ra[0] * rb[2];
        m01 = ra[0] * rb[1];
        m10 = ra[1] * rb[0];
        cross_vec[0] = $signed({m12[2*ROT_W-1], m12}) - $signed({m21[2*ROT_W-1], m21});
        cross_vec[1] = $signed({m20[2*ROT_W-1], m20}) - $signed({m02[2*ROT_W-1], m02});
        cross_vec[2] = $signed({m01[2*ROT_W-1], m01}) - $signed({m10[2*ROT_W-1], m10});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.axis_load)
        begin
            cross_reg <= (cmd.axis_idx >= FIRST_CROSS);
            for (int k = 0; k < 3; k++)
            begin
                if (cmd.axis_idx >= FIRST_CROSS)
                    axis_reg[k] <= cross_vec[k];
                else
                    axis_reg[k] <= AXIS_W'(ra[k]);
            end
        end
    end

    // Skip a cross axis whose components all stay within the limit
    always_comb
    begin
        big = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = axis_reg[k][AXIS_W-1] ? AXIS_W'(-axis_reg[k]) : AXIS_W'(axis_reg[k]);
            if (mag[k] > AXIS_W'(limit_reg))
                big = 1'b1;
        end
        st.skip      = cross_reg && !big;
        st.out_valid = out_valid_reg;
    end

    // Multiply the axis by one corner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= cmd.issue;
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg <= cmd.corner_idx;
        for (int k = 0; k < 3; k++)
            prod_reg[k] <= axis_reg[k] * corner_reg[cmd.corner_idx][k];
    end

    // Sum the products and track each box's extent
    assign sum = PROJ_W'(prod_reg[0]) + PROJ_W'(prod_reg[1]) + PROJ_W'(prod_reg[2]);
    assign box = p_idx_reg[3];

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            proj_reg[p_idx_reg] <= sum;
            if (p_idx_reg[2:0] == 3'd0)
            begin
                lo_reg[box] <= sum;
                hi_reg[box] <= sum;
            end
            else
            begin
                if (sum < lo_reg[box])
                    lo_reg[box] <= sum;
                if (sum > hi_reg[box])
                    hi_reg[box] <= sum;
            end
        end
    end

    // Drop corners that fall outside the other box on this axis
    always_comb
    begin
        for (int i = 0; i < N_CORNER; i++)
        begin
            if (i < 8)
                keep[i] = !(proj_reg[i] < lo_reg[1] || proj_reg[i] > hi_reg[1]);
            else
                keep[i] = !(proj_reg[i] < lo_reg[0] || proj_reg[i] > hi_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            mask_reg <= '1;
        else if (cmd.judge)
            mask_reg <= mask_reg & keep;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= {7'd0, mask_reg[15:8], mask_reg[7:0], |mask_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* sv/obb_corner_containment_test.sv */
`timescale 1ns / 1ps
// Load items are accepted only while idle; a load with tlast starts the test.
// Each kept axis passes through axis form, check, 16 corner dot products on
// one shared three-multiplier unit, drain and judge; a skipped cross axis
// passes through axis form and check only. The result is held back while an
// earlier result waits. No item is accepted while a test runs. Reset clears
// control and the limit; corner and rotation stores are undefined until written.
module obb_corner_containment_test
    import obb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,   // coord_x, coord_y, coord_z
    input  logic [4:0]          s_tuser,   // kind, box_sel, slot[2:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // colliding, first_inside_mask, second_inside_mask
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t st;

    obb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    obb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/sv/obb_corner_containment_test_tb.sv */
`timescale 1ns / 1ps
module obb_corner_containment_test_tb;
    import obb_pkg::*;

    localparam int  TEST_CYCLES = 310;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  ITEM_TARGET = 850;

    localparam bit  KIND_CORNER   = 1'b0;
    localparam bit  KIND_ROTATION = 1'b1;
    localparam bit  BOX_FIRST     = 1'b0;
    localparam bit  BOX_SECOND    = 1'b1;

    localparam int  ROT_AXIS_ALIGNED = 0;
    localparam int  ROT_RANDOM       = 1;
    localparam int  ROT_TINY         = 2;
    localparam int  ROT_ZERO         = 3;

    typedef struct {
        bit        kind;
        bit        box;
        bit [2:0]  slot;
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
    } load_t;

    typedef struct {
        bit       colliding;
        bit [7:0] first_mask;
        bit [7:0] second_mask;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    // Local copy of the box stores and the skip limit
    logic signed [COORD_W-1:0] corner_mem [N_CORNER][3];
    logic signed [ROT_W-1:0]   rot_mem [N_ROT][3];
    logic [LIMIT_W-1:0]        skip_limit;

    verdict_t expected_verdicts [$];
    int  errors;
    int  items_sent;
    int  verdicts_seen;
    int  collisions_seen;
    int  cycles = 0;
    bit  quiet;

    obb_corner_containment_test uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold the run to a cycle budget
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Work out collision flag and inside masks from the stored boxes
    function automatic verdict_t predict_containment();
        longint axes [15][3];
        longint ra [3];
        longint rb [3];
        longint c [3];
        longint big;
        logic signed [127:0] proj [16];
        logic signed [127:0] wa;
        logic signed [127:0] wc;
        logic signed [127:0] lo [2];
        logic signed [127:0] hi [2];
        bit [7:0] in_mask [2];
        int naxes;
        int i;
        int j;
        int k;
        verdict_t v;
        naxes = 0;
        for (i = 0; i < 3; i++)
        begin
            for (k = 0; k < 3; k++)
            begin
                axes[naxes][k]   = rot_mem[i][k];
                axes[naxes+1][k] = rot_mem[3+i][k];
            end
            naxes += 2;
        end
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                for (k = 0; k < 3; k++)
                begin
                    ra[k] = rot_mem[i][k];
                    rb[k] = rot_mem[3+j][k];
                end
                c[0] = ra[1] * rb[2] - ra[2] * rb[1];
                c[1] = ra[2] * rb[0] - ra[0] * rb[2];
                c[2] = ra[0] * rb[1] - ra[1] * rb[0];
                big = 0;
                for (k = 0; k < 3; k++)
                begin
                    if (c[k] > big)
                        big = c[k];
                    if (-c[k] > big)
                        big = -c[k];
                end
                if (big > longint'(skip_limit))
                begin
                    for (k = 0; k < 3; k++)
                        axes[naxes][k] = c[k];
                    naxes++;
                end
            end
        end
        in_mask[0] = 8'hFF;
        in_mask[1] = 8'hFF;
        for (int a = 0; a < naxes; a++)
        begin
            for (i = 0; i < 16; i++)
            begin
                proj[i] = '0;
                for (k = 0; k < 3; k++)
                begin
                    wa = axes[a][k];
                    wc = corner_mem[i][k];
                    proj[i] += wa * wc;
                end
            end
            for (j = 0; j < 2; j++)
            begin
                lo[j] = proj[j*8];
                hi[j] = proj[j*8];
                for (i = 1; i < 8; i++)
                begin
                    if (proj[j*8+i] < lo[j]) lo[j] = proj[j*8+i];
                    if (proj[j*8+i] > hi[j]) hi[j] = proj[j*8+i];
                end
            end
            for (j = 0; j < 2; j++)
                for (i = 0; i < 8; i++)
                    if (proj[j*8+i] < lo[1-j] || proj[j*8+i] > hi[1-j])
                        in_mask[j][i] = 1'b0;
        end
        v.colliding   = (in_mask[0] != 0) || (in_mask[1] != 0);
        v.first_mask  = in_mask[0];
        v.second_mask = in_mask[1];
        return v;
    endfunction

    // Apply an accepted request to the local stores; queue a verdict on tlast
    function automatic void absorb_request(input load_t it, input bit last);
        if (it.kind == KIND_CORNER)
        begin
            corner_mem[it.box*8 + it.slot][0] = it.x;
            corner_mem[it.box*8 + it.slot][1] = it.y;
            corner_mem[it.box*8 + it.slot][2] = it.z;
        end
        else if (it.slot < 3)
        begin
            rot_mem[it.box*3 + it.slot][0] = it.x[ROT_W-1:0];
            rot_mem[it.box*3 + it.slot][1] = it.y[ROT_W-1:0];
            rot_mem[it.box*3 + it.slot][2] = it.z[ROT_W-1:0];
        end
        if (last)
            expected_verdicts = {expected_verdicts, predict_containment()};
    endfunction

    // Send one request and wait for it to be taken
    task automatic send_request(input load_t it, input bit last);
        int gap;
        s_tdata  <= {it.z, it.y, it.x};
        s_tuser  <= {it.slot, it.box, it.kind};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        absorb_request(it, last);
        items_sent++;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every verdict and let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TEST_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip_limit(input logic [LIMIT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_limit = value;
    endtask

    function automatic longint rand_signed(input int unsigned range);
        return longint'($urandom_range(0, 2 * range)) - longint'(range);
    endfunction

    // Build the eleven load requests of one box around a centre
    task automatic build_box(input bit box, input longint cx, input longint cy,
                             input longint cz, input int style, ref load_t items[$]);
        longint col [3][3];
        longint half [3];
        longint cen [3];
        longint v [3];
        load_t it;
        int shift;
        shift = $urandom_range(0, 2);
        cen[0] = cx;
        cen[1] = cy;
        cen[2] = cz;
        for (int i = 0; i < 3; i++)
        begin
            half[i] = $urandom_range(1, 1024);
            for (int a = 0; a < 3; a++)
            begin
                case (style)
                    ROT_AXIS_ALIGNED:
                        col[i][a] = (a == (i + shift) % 3) ?
                                    ($urandom_range(0, 1) ? 16384 : -16384) : 0;
                    ROT_RANDOM: col[i][a] = rand_signed(16384);
                    ROT_TINY:   col[i][a] = rand_signed(100);
                    default:    col[i][a] = 0;
                endcase
            end
            it.kind = KIND_ROTATION;
            it.box  = box;
            it.slot = 3'(i);
            it.x = {16'($urandom_range(0, 65535)), col[i][0][15:0]};
            it.y = {16'($urandom_range(0, 65535)), col[i][1][15:0]};
            it.z = {16'($urandom_range(0, 65535)), col[i][2][15:0]};
            items = {items, it};
        end
        for (int k = 0; k < 8; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                v[a] = cen[a];
                for (int i = 0; i < 3; i++)
                    v[a] += (((k >> i) & 1) ? 4 : -4) * half[i] * col[i][a];
            end
            it.kind = KIND_CORNER;
            it.box  = box;
            it.slot = 3'(k);
            it.x = v[0][31:0];
            it.y = v[1][31:0];
            it.z = v[2][31:0];
            items = {items, it};
        end
    endtask

    // Load both boxes in shuffled order and start the test on the final request
    task automatic load_box_pair(input int style0, input int style1, input bit near);
        load_t items [$];
        load_t tmp;
        longint cx;
        longint cy;
        longint cz;
        int span;
        int j;
        cx = rand_signed(1 << 28);
        cy = rand_signed(1 << 28);
        cz = rand_signed(1 << 28);
        span = near ? (1 << 26) : (1 << 29);
        build_box(BOX_FIRST, cx, cy, cz, style0, items);
        build_box(BOX_SECOND, cx + rand_signed(span), cy + rand_signed(span),
                  cz + rand_signed(span), style1, items);
        for (int i = items.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = items[i];
            items[i] = items[j];
            items[j] = tmp;
        end
        foreach (items[i])
            send_request(items[i], i == items.size() - 1);
    endtask

    function automatic load_t noise_request();
        load_t it;
        it.kind = 1'($urandom_range(0, 1));
        it.box  = 1'($urandom_range(0, 1));
        it.slot = 3'($urandom_range(0, 7));
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        return it;
    endfunction

    // Take each verdict after a random stall and compare it field by field
    initial
    begin
        verdict_t want;
        int stall;
        m_tready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            verdicts_seen++;
            if (m_tdata[0])
                collisions_seen++;
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected verdict %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want.colliding)
                begin
                    $error("colliding: expected %0d, got %0d", want.colliding, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[8:1] !== want.first_mask)
                begin
                    $error("first_inside_mask: expected %h, got %h",
                           want.first_mask, m_tdata[8:1]);
                    errors++;
                end
                if (m_tdata[16:9] !== want.second_mask)
                begin
                    $error("second_inside_mask: expected %h, got %h",
                           want.second_mask, m_tdata[16:9]);
                    errors++;
                end
            end
        end
    end

    // Fill both boxes, then push field extremes and ignored rotation slots
    task automatic test_extremes();
        load_t it;
        load_box_pair(ROT_RANDOM, ROT_RANDOM, 1'b1);
        it = '{KIND_CORNER, BOX_FIRST, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_request(it, 1'b1);
        it = '{KIND_CORNER, BOX_SECOND, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_request(it, 1'b1);
        it = '{KIND_ROTATION, BOX_SECOND, 3'd2, 32'hFFFF_7FFF, 32'h0000_8000, 32'hA5A5_0000};
        send_request(it, 1'b1);
        it = '{KIND_ROTATION, BOX_FIRST, 3'd0, 32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_7FFF};
        send_request(it, 1'b0);
        it = '{KIND_ROTATION, BOX_FIRST, 3'd3, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678};
        send_request(it, 1'b1);
        it = '{KIND_ROTATION, BOX_SECOND, 3'd7, 32'h0, 32'hFFFF_FFFF, 32'h0};
        send_request(it, 1'b1);
        it = '{KIND_CORNER, BOX_FIRST, 3'd4, 32'h0, 32'hFFFF_FFFF, 32'h0};
        send_request(it, 1'b1);
    endtask

    // A box with all rotation columns zero projects to a single point
    task automatic test_degenerate_box();
        load_box_pair(ROT_RANDOM, ROT_ZERO, 1'b1);
        load_box_pair(ROT_ZERO, ROT_AXIS_ALIGNED, 1'b1);
    endtask

    // With the top limit, two tiny-column boxes drop every cross axis; then an axis-aligned box meets a tiny one
    task automatic test_cross_axes_skipped();
        drain();
        write_skip_limit(16'hFFFF);
        load_box_pair(ROT_TINY, ROT_TINY, 1'b1);
        load_box_pair(ROT_AXIS_ALIGNED, ROT_TINY, 1'b1);
    endtask

    // Mostly well-formed box pairs, with partial updates and noise mixed in
    task automatic test_random_loads(input logic [LIMIT_W-1:0] limit, input int budget);
        int stop_at;
        int pick;
        int n;
        int styles [2];
        drain();
        write_skip_limit(limit);
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                styles[0] = $urandom_range(ROT_AXIS_ALIGNED, ROT_TINY);
                styles[1] = $urandom_range(ROT_AXIS_ALIGNED, ROT_TINY);
                load_box_pair(styles[0], styles[1], $urandom_range(0, 3) != 0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_request(noise_request(),
                                 (i == n - 1) ? 1'b1 : ($urandom_range(0, 7) == 0));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        verdicts_seen = 0;
        collisions_seen = 0;
        quiet = 1'b0;
        skip_limit = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_degenerate_box();
        test_cross_axes_skipped();
        test_random_loads(16'd0, 200);
        test_random_loads(16'hFFFF, 200);
        test_random_loads(16'($urandom_range(1, 65534)), 200);
        test_random_loads(16'd1000, ITEM_TARGET - items_sent);

        drain();
        $display("Sent %0d load requests across four skip-limit settings and degenerate boxes;",
                 items_sent);
        $display("checked %0d verdicts, %0d of them collisions.", verdicts_seen,
                 collisions_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/obb_pkg.sv
sv/obb_ctrl.sv
sv/obb_datapath.sv
sv/obb_corner_containment_test.sv
tb/sv/obb_corner_containment_test_tb.sv
